/* rtl/ams_pkg.sv */
// Shared types, constants and defaults for the adjacency matrix store.
package ams_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int REQ_W  = 2;
    localparam int VTX_W  = 5;
    localparam int WIN_W  = 16;
    localparam int STAT_W = 2;
    localparam int TOT_W  = 5;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_EDGE   = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_CLEAR,
        S_ROWS,
        S_DRAIN,
        S_COLS,
        S_EDGE_A,
        S_EDGE_B,
        S_READ,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic clr_step;
        logic row_step;
        logic col_init;
        logic col_step;
        logic edge_a;
        logic edge_b;
        logic rd;
        logic push;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic ok;
        logic no_shift;
        logic clr_last;
        logic loop_last;
        logic out_free;
    } stat_t;

endpackage

/* rtl/ams_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ams_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/ams_ctrl.sv */
// Controller state machine that sequences each request through the datapath.
module ams_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ams_pkg::stat_t st,
    output ams_pkg::cmd_t  cmd
);

    ams_pkg::state_t state_reg;
    ams_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ams_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ams_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ams_pkg::S_DECIDE;
                end
            end
            ams_pkg::S_DECIDE: begin
                if (!st.ok) begin
                    state_next = ams_pkg::S_FINISH;
                end else begin
                    case (st.req)
                        ams_pkg::REQ_INSERT: state_next = ams_pkg::S_CLEAR;
                        ams_pkg::REQ_DELETE: begin
                            state_next = st.no_shift ? ams_pkg::S_FINISH : ams_pkg::S_ROWS;
                        end
                        ams_pkg::REQ_EDGE:   state_next = ams_pkg::S_EDGE_A;
                        ams_pkg::REQ_READ:   state_next = ams_pkg::S_READ;
                        default:             state_next = ams_pkg::S_FINISH;
                    endcase
                end
            end
            ams_pkg::S_CLEAR: begin
                if (st.clr_last) begin
                    state_next = ams_pkg::S_FINISH;
                end
            end
            ams_pkg::S_ROWS: begin
                if (st.loop_last) begin
                    state_next = ams_pkg::S_DRAIN;
                end
            end
            ams_pkg::S_DRAIN:  state_next = ams_pkg::S_COLS;
            ams_pkg::S_COLS: begin
                if (st.loop_last) begin
                    state_next = ams_pkg::S_FINISH;
                end
            end
            ams_pkg::S_EDGE_A: state_next = ams_pkg::S_EDGE_B;
            ams_pkg::S_EDGE_B: state_next = ams_pkg::S_FINISH;
            ams_pkg::S_READ:   state_next = ams_pkg::S_FINISH;
            ams_pkg::S_FINISH: begin
                if (st.out_free) begin
                    state_next = ams_pkg::S_IDLE;
                end
            end
            default: state_next = ams_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ams_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ams_pkg::S_DECIDE: cmd.decide   = 1'b1;
            ams_pkg::S_CLEAR:  cmd.clr_step = 1'b1;
            ams_pkg::S_ROWS:   cmd.row_step = 1'b1;
            ams_pkg::S_DRAIN:  cmd.col_init = 1'b1;
            ams_pkg::S_COLS:   cmd.col_step = 1'b1;
            ams_pkg::S_EDGE_A: cmd.edge_a   = 1'b1;
            ams_pkg::S_EDGE_B: cmd.edge_b   = 1'b1;
            ams_pkg::S_READ:   cmd.rd       = 1'b1;
            ams_pkg::S_FINISH: cmd.push     = st.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/ams_dp.sv */
// Datapath: request registers, vertex count, loop counters, weight memory and result register.
module ams_dp #(
    parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = ams_pkg::WEIGHT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ams_pkg::REQ_W-1:0]    in_req,
    input  logic [ams_pkg::VTX_W-1:0]    in_va,
    input  logic [ams_pkg::VTX_W-1:0]    in_vb,
    input  logic [ams_pkg::WIN_W-1:0]    in_w,
    input  ams_pkg::cmd_t                cmd,
    output ams_pkg::stat_t               st,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [ams_pkg::STAT_W-1:0]   out_status,
    output logic [ams_pkg::TOT_W-1:0]    out_total,
    output logic [ams_pkg::WIN_W-1:0]    out_weight
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W  = (CNT_W > ams_pkg::VTX_W) ? CNT_W : ams_pkg::VTX_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    ams_pkg::req_t                 req_reg;
    logic [ams_pkg::VTX_W-1:0]     va_reg;
    logic [ams_pkg::VTX_W-1:0]     vb_reg;
    logic [ams_pkg::WIN_W-1:0]     w_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    ams_pkg::status_t              stat_reg, stat_next;
    logic [IDX_W-1:0]              i_reg, i_next;
    logic [IDX_W-1:0]              j_reg, j_next;
    logic                          h_reg, h_next;
    logic                          pend_reg;
    logic [ADDR_W-1:0]             pend_addr_reg, pend_addr_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ams_pkg::STAT_W-1:0]    m_stat_reg;
    logic [ams_pkg::TOT_W-1:0]     m_total_reg;
    logic [ams_pkg::WIN_W-1:0]     m_weight_reg;

    logic [CMP_W-1:0]              a_ext, b_ext, cnt_ext;
    logic                          a_ok, b_ok, full;
    logic [IDX_W-1:0]              am1, bm1, nm1, nm2, ip1;
    logic                          j_wrap;
    logic                          we, re;
    logic [ADDR_W-1:0]             waddr, raddr;
    logic [WEIGHT_BITS-1:0]        wdata, rdata;

    assign a_ext   = CMP_W'(va_reg);
    assign b_ext   = CMP_W'(vb_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign a_ok    = (va_reg != '0) && (a_ext <= cnt_ext);
    assign b_ok    = (vb_reg != '0) && (b_ext <= cnt_ext);
    assign full    = (count_reg >= CNT_W'(MAX_VERTICES));

    assign am1    = IDX_W'(va_reg - ams_pkg::VTX_W'(1));
    assign bm1    = IDX_W'(vb_reg - ams_pkg::VTX_W'(1));
    assign nm1    = IDX_W'(n_reg - CNT_W'(1));
    assign nm2    = IDX_W'(n_reg - CNT_W'(2));
    assign ip1    = i_reg + IDX_W'(1);
    assign j_wrap = (j_reg == nm1);

    always_comb begin
        stat_next = ams_pkg::ST_OK;
        case (req_reg)
            ams_pkg::REQ_INSERT: stat_next = full ? ams_pkg::ST_FULL : ams_pkg::ST_OK;
            ams_pkg::REQ_DELETE: stat_next = a_ok ? ams_pkg::ST_OK : ams_pkg::ST_RANGE;
            default:             stat_next = (a_ok && b_ok) ? ams_pkg::ST_OK : ams_pkg::ST_RANGE;
        endcase
    end

    assign st.req       = req_reg;
    assign st.ok        = (stat_next == ams_pkg::ST_OK);
    assign st.no_shift  = (a_ext == cnt_ext);
    assign st.clr_last  = j_wrap && h_reg;
    assign st.loop_last = (i_reg == nm2) && j_wrap;
    assign st.out_free  = !m_valid_reg || m_tready;

    always_comb begin
        count_next = count_reg;
        n_next     = n_reg;
        if (cmd.decide) begin
            if (req_reg == ams_pkg::REQ_INSERT) begin
                n_next = count_reg + CNT_W'(1);
            end else begin
                n_next = count_reg;
            end
            if (stat_next == ams_pkg::ST_OK) begin
                if (req_reg == ams_pkg::REQ_INSERT) begin
                    count_next = count_reg + CNT_W'(1);
                end else if (req_reg == ams_pkg::REQ_DELETE) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        h_next = h_reg;
        if (cmd.decide || cmd.col_init) begin
            i_next = am1;
            j_next = '0;
            h_next = 1'b0;
        end else if (cmd.clr_step) begin
            h_next = !h_reg;
            if (h_reg) begin
                j_next = j_reg + IDX_W'(1);
            end
        end else if (cmd.row_step || cmd.col_step) begin
            if (j_wrap) begin
                j_next = '0;
                i_next = ip1;
            end else begin
                j_next = j_reg + IDX_W'(1);
            end
        end
    end

    always_comb begin
        re    = cmd.row_step || cmd.col_step || cmd.rd;
        raddr = {am1, bm1};
        if (cmd.row_step) begin
            raddr = {ip1, j_reg};
        end else if (cmd.col_step) begin
            raddr = {j_reg, ip1};
        end
        pend_addr_next = cmd.row_step ? {i_reg, j_reg} : {j_reg, i_reg};
    end

    always_comb begin
        we    = pend_reg || cmd.clr_step || cmd.edge_a || cmd.edge_b;
        waddr = pend_addr_reg;
        wdata = rdata;
        if (!pend_reg) begin
            if (cmd.clr_step) begin
                waddr = h_reg ? {j_reg, nm1} : {nm1, j_reg};
                wdata = '0;
            end else begin
                waddr = cmd.edge_a ? {am1, bm1} : {bm1, am1};
                wdata = WEIGHT_BITS'($signed(w_reg));
            end
        end
    end

    ams_ram #(
        .DATA_W (WEIGHT_BITS),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= cmd.row_step || cmd.col_step;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= ams_pkg::req_t'(in_req);
            va_reg  <= in_va;
            vb_reg  <= in_vb;
            w_reg   <= in_w;
        end
        if (cmd.decide) begin
            stat_reg <= stat_next;
        end
        n_reg         <= n_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        h_reg         <= h_next;
        pend_addr_reg <= pend_addr_next;
        if (cmd.push) begin
            m_stat_reg  <= stat_reg;
            m_total_reg <= ams_pkg::TOT_W'(count_reg);
            if ((stat_reg == ams_pkg::ST_OK) && (req_reg == ams_pkg::REQ_READ)) begin
                m_weight_reg <= ams_pkg::WIN_W'($signed(rdata));
            end else begin
                m_weight_reg <= '0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign out_status = m_stat_reg;
    assign out_total  = m_total_reg;
    assign out_weight = m_weight_reg;

endmodule

/* rtl/adjacency_matrix_store_core.sv */
// Top level of the weighted undirected adjacency matrix store.
//
// Requests arrive on the s_ channel: s_tuser carries the request kind (insert vertex,
// delete vertex, add edge, read entry) and s_tdata the vertices and the edge weight.
// Every request produces exactly one result transaction on the m_ channel: m_tuser
// carries the status (ok, store full, vertex out of range), m_tdata the live vertex
// count and the weight returned by a read.
// One request is processed at a time; s_tready is high only while the controller idles.
// An insert clears the new row and column one entry per cycle. A delete shifts every
// row and column after the deleted vertex, and each moved entry takes one pass
// through the single read and single write port of the weight memory; deleting the
// last vertex moves nothing.
// The next request is accepted only once the previous one has pushed its result.
// The result sits in an output register, so a new request is accepted while the
// previous result waits; a stalled receiver holds the next result in its final state.
// Reset clears the vertex count and the handshake state. The weight memory is not
// cleared; insert zeroes every entry that it brings into use.
module adjacency_matrix_store_core #(
    parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = ams_pkg::WEIGHT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vertex_a [4:0], vertex_b [9:5], edge_weight [25:10], zero fill [31:26]
    input  logic [ams_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [1:0]
    input  logic [ams_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // vertex_total [4:0], read_weight [20:5], zero fill [23:21]
    output logic [ams_pkg::M_TDATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [ams_pkg::STAT_W-1:0]      m_tuser
);

    ams_pkg::cmd_t               cmd;
    ams_pkg::stat_t              st;
    logic [ams_pkg::TOT_W-1:0]   total;
    logic [ams_pkg::WIN_W-1:0]   weight;

    ams_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ams_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_req     (s_tuser),
        .in_va      (s_tdata[4:0]),
        .in_vb      (s_tdata[9:5]),
        .in_w       (s_tdata[25:10]),
        .cmd        (cmd),
        .st         (st),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (m_tuser),
        .out_total  (total),
        .out_weight (weight)
    );

    assign m_tdata = {3'b000, weight, total};

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the adjacency matrix store: random requests against a matrix predictor.
module tb_top;
    import ams_pkg::*;

    localparam int MAXV       = MAX_VERTICES_DEF;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 575;

    typedef struct {
        req_t        kind;
        logic [4:0]  va;
        logic [4:0]  vb;
        logic [15:0] w;
        int          gap;
    } request_t;

    typedef struct {
        status_t     st;
        logic [4:0]  total;
        logic [15:0] rd;
    } reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    request_t    requests[$];
    reply_t      due_replies[$];
    logic [15:0] weights [1:MAXV][1:MAXV];
    int          live_count = 0;
    int          gen_count = 0;
    int          req_total = 0;
    int          req_taken = 0;
    int          replies_seen = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    logic        long_hold_done = 1'b0;
    logic        s_took = 1'b0;

    adjacency_matrix_store_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic add_req(input req_t kind, input int va, input int vb, input int w,
                           input int gap);
        request_t q;
        q.kind = kind;
        q.va = 5'(va);
        q.vb = 5'(vb);
        q.w = 16'(w);
        q.gap = gap;
        requests.push_back(q);
        req_total++;
        if (kind == REQ_INSERT && gen_count < MAXV)
            gen_count++;
        else if (kind == REQ_DELETE && va >= 1 && va <= gen_count)
            gen_count--;
    endtask

    function automatic int pick_vertex();
        if (gen_count == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 31);
        return $urandom_range(1, gen_count);
    endfunction

    task automatic apply_request(input request_t q);
        reply_t r;
        int n;
        int a;
        int b;
        r.st = ST_OK;
        r.rd = '0;
        a = q.va;
        b = q.vb;
        n = live_count;
        case (q.kind)
            REQ_INSERT: begin
                if (n >= MAXV) begin
                    r.st = ST_FULL;
                end else begin
                    n++;
                    for (int k = 1; k <= n; k++) begin
                        weights[n][k] = '0;
                        weights[k][n] = '0;
                    end
                    live_count = n;
                end
            end
            REQ_DELETE: begin
                if (a < 1 || a > n) begin
                    r.st = ST_RANGE;
                end else begin
                    for (int rr = a; rr < n; rr++)
                        for (int c = 1; c <= n; c++)
                            weights[rr][c] = weights[rr + 1][c];
                    for (int c = a; c < n; c++)
                        for (int rr = 1; rr <= n; rr++)
                            weights[rr][c] = weights[rr][c + 1];
                    live_count = n - 1;
                end
            end
            default: begin
                if (a < 1 || a > n || b < 1 || b > n) begin
                    r.st = ST_RANGE;
                end else if (q.kind == REQ_EDGE) begin
                    weights[a][b] = q.w;
                    weights[b][a] = q.w;
                end else begin
                    r.rd = weights[a][b];
                end
            end
        endcase
        r.total = 5'(live_count);
        due_replies.push_back(r);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_took)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (requests.size() > 0) begin
                request_t q;
                q = requests.pop_front();
                s_tdata <= {6'b0, q.w, q.vb, q.va};
                s_tuser <= q.kind;
                s_tvalid <= 1'b1;
                gap_left <= q.gap;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!long_hold_done && replies_seen >= 150) begin
            hold_left <= 400;
            long_hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (replies_seen >= 400 && replies_seen < 460) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            hold_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results outstanding", $time, due_replies.size());
            $display("FAIL");
            $finish;
        end
        s_took <= s_tvalid && s_tready;
        if (m_tvalid && m_tready) begin
            replies_seen <= replies_seen + 1;
            if (due_replies.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result status %0d total %0d weight %0d",
                         $time, m_tuser, m_tdata[4:0], $signed(m_tdata[20:5]));
            end else begin
                reply_t e;
                e = due_replies.pop_front();
                if (m_tuser !== e.st) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, e.st, m_tuser);
                end
                if (m_tdata[4:0] !== e.total) begin
                    mismatches++;
                    $display("%0t: vertex_total expected %0d actual %0d",
                             $time, e.total, m_tdata[4:0]);
                end
                if (m_tdata[20:5] !== e.rd) begin
                    mismatches++;
                    $display("%0t: read_weight expected %0d actual %0d",
                             $time, $signed(e.rd), $signed(m_tdata[20:5]));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            request_t q;
            q.kind = req_t'(s_tuser);
            q.va = s_tdata[4:0];
            q.vb = s_tdata[9:5];
            q.w = s_tdata[25:10];
            q.gap = 0;
            apply_request(q);
            req_taken <= req_taken + 1;
        end
    end

    initial begin
        int roll;
        int gap;
        logic grow;
        // An empty store rejects every vertex, including the largest value the field can carry.
        add_req(REQ_READ, 1, 1, 0, 0);
        add_req(REQ_DELETE, 1, 0, 0, 1);
        add_req(REQ_EDGE, 31, 0, -1, 0);
        for (int i = 0; i < MAXV; i++)
            add_req(REQ_INSERT, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 65535), i % 3);
        add_req(REQ_INSERT, 0, 0, 0, 0);
        add_req(REQ_EDGE, 1, 16, -32768, 0);
        add_req(REQ_EDGE, 16, 16, 32767, 2);
        add_req(REQ_DELETE, 1, 31, -1, 0);
        add_req(REQ_READ, 15, 15, -1, 0);
        add_req(REQ_DELETE, 15, 0, 0, 0);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            grow = ((i / 120) % 2) == 0;
            gap = (i % 150 >= 100 && i % 150 < 140) ? 0 : pick_gap();
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 35 : 10))
                add_req(REQ_INSERT, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 65535), gap);
            else if (roll < (grow ? 43 : 35))
                add_req(REQ_DELETE, pick_vertex(), $urandom_range(0, 31),
                        $urandom_range(0, 65535), gap);
            else if (roll < 70)
                add_req(REQ_EDGE, pick_vertex(), pick_vertex(), $urandom_range(0, 65535), gap);
            else
                add_req(REQ_READ, pick_vertex(), pick_vertex(), $urandom_range(0, 65535), gap);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (req_taken < req_total || due_replies.size() > 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && due_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
